// File: rtl/rsc_pkg.sv
// Shared types, constants and rotor functions for the rotor stream cipher.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    typedef logic [3:0] nib_t;

    // Command codes carried on the request channel.
    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_ENC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_0_3   = 3'd0;
    localparam logic [2:0] REG_KEY_4_7   = 3'd1;
    localparam logic [2:0] REG_KEY_8_11  = 3'd2;
    localparam logic [2:0] REG_KEY_12_15 = 3'd3;
    localparam logic [2:0] REG_IV_0_3    = 3'd4;
    localparam logic [2:0] REG_IV_4_7    = 3'd5;

    localparam logic [15:0] LFSR_TAPS = 16'hCA44;
    localparam logic [15:0] SEED_BIT  = 16'h0100;
    localparam logic [1:0]  LAST_PASS = 2'd3;
    localparam logic [2:0]  LAST_STEP = 3'd7;

    localparam nib_t SB1 [16] = '{4'd1, 4'd15, 4'd11, 4'd2, 4'd0, 4'd3, 4'd5, 4'd8,
                                  4'd6, 4'd9, 4'd12, 4'd7, 4'd13, 4'd10, 4'd14, 4'd4};
    localparam nib_t SB2 [16] = '{4'd6, 4'd10, 4'd15, 4'd4, 4'd14, 4'd13, 4'd9, 4'd2,
                                  4'd1, 4'd7, 4'd12, 4'd11, 4'd0, 4'd3, 4'd5, 4'd8};
    localparam nib_t SB3 [16] = '{4'd12, 4'd2, 4'd6, 4'd1, 4'd0, 4'd3, 4'd5, 4'd8,
                                  4'd7, 4'd9, 4'd11, 4'd14, 4'd10, 4'd13, 4'd15, 4'd4};
    localparam nib_t SB4 [16] = '{4'd13, 4'd11, 4'd2, 4'd7, 4'd0, 4'd3, 4'd5, 4'd8,
                                  4'd6, 4'd12, 4'd15, 4'd1, 4'd10, 4'd4, 4'd9, 4'd14};
    localparam nib_t IB1 [16] = '{4'd4, 4'd0, 4'd3, 4'd5, 4'd15, 4'd6, 4'd8, 4'd11,
                                  4'd7, 4'd9, 4'd13, 4'd2, 4'd10, 4'd12, 4'd14, 4'd1};
    localparam nib_t IB2 [16] = '{4'd12, 4'd8, 4'd7, 4'd13, 4'd3, 4'd14, 4'd0, 4'd9,
                                  4'd15, 4'd6, 4'd1, 4'd11, 4'd10, 4'd5, 4'd4, 4'd2};
    localparam nib_t IB3 [16] = '{4'd4, 4'd3, 4'd1, 4'd5, 4'd15, 4'd6, 4'd2, 4'd8,
                                  4'd7, 4'd9, 4'd12, 4'd10, 4'd0, 4'd13, 4'd11, 4'd14};
    localparam nib_t IB4 [16] = '{4'd4, 4'd11, 4'd2, 4'd5, 4'd13, 4'd6, 4'd8, 4'd3,
                                  4'd7, 4'd14, 4'd12, 4'd1, 4'd9, 4'd0, 4'd15, 4'd10};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_INIT_FIX,
        ST_ENC,
        ST_DEC,
        ST_UPDATE
    } rsc_state_t;

    function automatic logic [15:0] subst_fwd(input logic [15:0] x);
        subst_fwd = {SB1[x[15:12]], SB2[x[11:8]], SB3[x[7:4]], SB4[x[3:0]]};
    endfunction

    function automatic logic [15:0] subst_inv(input logic [15:0] x);
        subst_inv = {IB1[x[15:12]], IB2[x[11:8]], IB3[x[7:4]], IB4[x[3:0]]};
    endfunction

    function automatic logic [15:0] mix(input logic [15:0] x);
        nib_t a, b, c, d;
        logic [15:0] y;
        a = x[15:12] ^ x[7:4];
        b = x[11:8] ^ x[3:0];
        c = x[7:4] ^ b;
        d = x[3:0] ^ a;
        y = {a, b, c, d};
        mix = y ^ {y[3:0], y[15:4]} ^ {y[7:0], y[15:8]};
    endfunction

    function automatic logic [15:0] unmix(input logic [15:0] x);
        nib_t a, b, c, d;
        logic [15:0] y;
        y = x ^ {x[11:0], x[15:12]} ^ {x[7:0], x[15:8]};
        a = y[15:12];
        b = y[11:8];
        c = y[7:4];
        d = y[3:0];
        d = d ^ a;
        c = c ^ b;
        b = b ^ d;
        a = a ^ c;
        unmix = {a, b, c, d};
    endfunction

    // Derived round key: rotated key word with the S-box nibble ORed in,
    // then XORed with a small rotor-dependent constant.
    function automatic logic [15:0] derive_key(input logic [15:0] t, input nib_t tweak);
        logic [15:0] u;
        u = t;
        u[9:6] = t[9:6] | SB1[t[9:6]];
        derive_key = u ^ {12'd0, tweak};
    endfunction

    function automatic logic [15:0] enc_rotor(input logic [15:0] x,
                                              input logic [15:0] k0, input logic [15:0] k1,
                                              input logic [15:0] k2, input logic [15:0] k3);
        logic [15:0] t;
        t = mix(subst_fwd(x ^ k0));
        t = mix(subst_fwd(t ^ k1));
        t = mix(subst_fwd(t ^ k2));
        t = mix(subst_fwd(t ^ k3));
        t = subst_fwd(t ^ k1 ^ k0);
        enc_rotor = t ^ k2 ^ k3;
    endfunction

    function automatic logic [15:0] dec_rotor(input logic [15:0] x,
                                              input logic [15:0] k0, input logic [15:0] k1,
                                              input logic [15:0] k2, input logic [15:0] k3);
        logic [15:0] t;
        t = subst_inv(x ^ k3 ^ k2) ^ k0 ^ k1;
        t = subst_inv(unmix(t)) ^ k3;
        t = subst_inv(unmix(t)) ^ k2;
        t = subst_inv(unmix(t)) ^ k1;
        dec_rotor = subst_inv(unmix(t)) ^ k0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rsc_req_if.sv
// Request channel interface: command and data word with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

`default_nettype wire

// File: rtl/rsc_rsp_if.sv
// Result channel interface: output data word with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// File: rtl/rotor_stream_cipher_16bit.sv
// Top level of the eight-rotor 16-bit word stream cipher.
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake        Payload
// req_ch       in         valid/ready      cmd[1:0], data_in[15:0]
// rsp_ch       out        valid/ready      data_out[15:0]
// cfg port     in         cfg_wr_en only   cfg_index[2:0], cfg_data[63:0]
//
// One rotor unit (five unrolled SPN rounds, encrypt or decrypt direction) is
// used once per cycle under a small sequencer, so a word passes through the
// eight rotors in turn and then a state update step: a request is accepted,
// its result is loaded into the output register by the update step, and the
// next request is taken once the block is back in idle. Initialize runs four
// passes of the eight rotors and a fix-up step each, and gives no result.
// Reset clears the rotor words, the feedback register, the key and IV
// registers and all control state. A stalled result holds in the output
// register while the next request is accepted; only the state update of a
// following word waits for the output register to drain.
module rotor_stream_cipher_16bit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rsc_req_if.sink          req_ch,
    rsc_rsp_if.source        rsp_ch,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import rsc_pkg::*;

    // Configuration registers: four key registers, two IV registers.
    logic [63:0] key_reg [4];
    logic [63:0] iv_reg  [2];

    // Cipher state.
    logic [15:0] s_reg  [8];
    logic [15:0] s_next [8];
    logic [15:0] fb_reg;
    logic [15:0] fb_next;

    // Sequencer.
    rsc_state_t  state_reg;
    rsc_state_t  state_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [1:0]  pass_reg;
    logic [1:0]  pass_next;

    // Working values: the chained word and the per-rotor outputs of one word.
    logic [15:0] x_reg;
    logic [15:0] x_next;
    logic [15:0] v_reg  [8];
    logic [15:0] v_next [8];

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;

    // Rotor unit signals.
    logic [63:0] key_sel;
    logic [31:0] key_pair;
    logic [15:0] k0, k1, k2, k3;
    logic [15:0] s_cur;
    logic [15:0] sum4;
    logic [15:0] enc_in;
    logic [15:0] enc_out;
    logic [15:0] dec_out;
    logic [15:0] dec_y;
    logic [2:0]  step_m1;
    logic        req_fire;

    // Update arithmetic.
    logic [15:0] s4_mid;
    logic [15:0] fb_step;

    assign req_ch.ready    = (state_reg == ST_IDLE);
    assign req_fire        = req_ch.valid && req_ch.ready;
    assign rsp_ch.valid    = out_valid_reg;
    assign rsp_ch.data_out = out_data_reg;

    // Configuration writes. Indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            iv_reg[0] <= '0;
            iv_reg[1] <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_0_3:   key_reg[0] <= cfg_data;
                REG_KEY_4_7:   key_reg[1] <= cfg_data;
                REG_KEY_8_11:  key_reg[2] <= cfg_data;
                REG_KEY_12_15: key_reg[3] <= cfg_data;
                REG_IV_0_3:    iv_reg[0]  <= cfg_data;
                REG_IV_4_7:    iv_reg[1]  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Rotor r = step + 1 uses key words 2*step and 2*step + 1, which sit in
    // one half of key register step / 2.
    assign key_sel  = key_reg[step_reg[2:1]];
    assign key_pair = step_reg[0] ? key_sel[63:32] : key_sel[31:0];
    assign k0       = key_pair[15:0];
    assign k1       = key_pair[31:16];
    assign k2       = derive_key({k0[9:0], k0[15:10]}, {1'b0, step_reg} + 4'd3);
    assign k3       = derive_key({k1[5:0], k1[15:6]}, {1'b0, step_reg} + 4'd4);

    assign s_cur   = s_reg[step_reg];
    assign step_m1 = step_reg - 3'd1;
    assign sum4    = s_reg[0] + s_reg[2] + s_reg[4] + s_reg[6];

    // The first rotor of an initialize pass takes the sum of the even words;
    // every other encrypt step takes the chained word plus the rotor word.
    assign enc_in  = (state_reg == ST_INIT && step_reg == 3'd0) ? sum4 : x_reg + s_cur;
    assign enc_out = enc_rotor(enc_in, k0, k1, k2, k3);
    assign dec_out = dec_rotor(x_reg, k0, k1, k2, k3);
    assign dec_y   = dec_out - s_cur;

    // Galois LFSR step and the intermediate fifth word used by word zero.
    assign fb_step = {1'b0, fb_reg[15:1]} ^ (fb_reg[0] ? LFSR_TAPS : 16'd0);
    assign s4_mid  = s_reg[4] + v_reg[1];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        x_next         = x_reg;
        fb_next        = fb_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 8; i++)
        begin
            s_next[i] = s_reg[i];
            v_next[i] = v_reg[i];
        end

        if (out_valid_reg && rsp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req_ch.cmd)
                        CMD_INIT:
                        begin
                            s_next[0] = iv_reg[0][15:0];
                            s_next[1] = iv_reg[0][31:16];
                            s_next[2] = iv_reg[0][47:32];
                            s_next[3] = iv_reg[0][63:48];
                            s_next[4] = iv_reg[1][15:0];
                            s_next[5] = iv_reg[1][31:16];
                            s_next[6] = iv_reg[1][47:32];
                            s_next[7] = iv_reg[1][63:48];
                            step_next  = 3'd0;
                            pass_next  = 2'd0;
                            state_next = ST_INIT;
                        end
                        CMD_ENC:
                        begin
                            x_next     = req_ch.data_in;
                            step_next  = 3'd0;
                            state_next = ST_ENC;
                        end
                        CMD_DEC:
                        begin
                            x_next     = req_ch.data_in;
                            v_next[7]  = req_ch.data_in;
                            step_next  = LAST_STEP;
                            state_next = ST_DEC;
                        end
                        default:
                        begin
                            // The unused command is dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                x_next = enc_out;
                if (step_reg != 3'd0)
                begin
                    s_next[step_reg] = s_cur + x_reg;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_INIT_FIX;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_INIT_FIX:
            begin
                s_next[0] = s_reg[0] + x_reg;
                step_next = 3'd0;
                if (pass_reg == LAST_PASS)
                begin
                    fb_next    = x_reg | SEED_BIT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = ST_INIT;
                end
            end
            ST_ENC:
            begin
                x_next           = enc_out;
                v_next[step_reg] = enc_out;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DEC:
            begin
                x_next = dec_y;
                if (step_reg == 3'd0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    v_next[step_m1] = dec_y;
                    step_next       = step_m1;
                end
            end
            ST_UPDATE:
            begin
                // Wait here until the output register is free.
                if (!out_valid_reg || rsp_ch.ready)
                begin
                    s_next[1] = s_reg[1] + v_reg[0] + v_reg[4] + s_reg[5];
                    s_next[2] = s_reg[2] + v_reg[1] + v_reg[2] + s_reg[3] + s_reg[0];
                    s_next[3] = s_reg[3] + v_reg[0] + v_reg[3] + s_reg[7];
                    s_next[5] = s_reg[5] + v_reg[0] + v_reg[3] + s_reg[6];
                    s_next[6] = s_reg[6] + v_reg[1] + v_reg[5];
                    s_next[7] = s_reg[7] + v_reg[3];
                    s_next[0] = s_reg[0] + v_reg[2] + v_reg[1] + s4_mid + v_reg[6];
                    s_next[4] = s4_mid + fb_step;
                    fb_next        = fb_step;
                    out_data_next  = x_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
            fb_reg        <= '0;
            for (int i = 0; i < 8; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            fb_reg        <= fb_next;
            for (int i = 0; i < 8; i++)
            begin
                s_reg[i] <= s_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

    // A result only appears out of the state update cycle.
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result raised outside the update cycle");

    // After the last initialize pass the feedback register has its seed bit.
    a_seed_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT_FIX && pass_reg == LAST_PASS) |=> fb_reg[8])
        else $error("feedback register seeded without bit 8");

    // The update waits while an earlier result is still held.
    a_update_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && out_valid_reg && !rsp_ch.ready)
        |=> (state_reg == ST_UPDATE && $stable(fb_reg)))
        else $error("state updated while the output register was full");

    // Encryption starts at the first rotor, decryption at the last.
    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && (state_next == ST_ENC || state_next == ST_DEC))
        |=> (step_reg == ((state_reg == ST_ENC) ? 3'd0 : LAST_STEP)))
        else $error("word started at the wrong rotor");

endmodule

`default_nettype wire

// File: tb/rotor_stream_cipher_16bit_test.sv
// Self-checking testbench for the eight-rotor 16-bit word stream cipher.
`timescale 1ns / 1ps

module rotor_stream_cipher_16bit_test;
    import rsc_pkg::*;

    // Command code that the block must ignore. Register indexes past the
    // last key/IV register must be ignored too.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] REG_STRAY_6 = 3'd6;
    localparam logic [2:0] REG_STRAY_7 = 3'd7;
    localparam int         REG_COUNT   = 6;

    localparam logic [15:0] FEEDBACK_TAPS = 16'hCA44;
    localparam logic [15:0] FEEDBACK_SEED = 16'h0100;

    // Initialize gives no result, so idle periods before a register write or
    // the end of the run must outlast a whole initialize.
    localparam int SETTLE_CYCLES  = 60;
    // Cycles with neither a request nor a result accepted before we give up.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 7;
    localparam int SEGMENT_ITEMS  = 200;

    // Forward and inverse nibble substitution tables, one per nibble lane.
    localparam nib_t FWD_A [16] = '{1, 15, 11, 2, 0, 3, 5, 8, 6, 9, 12, 7, 13, 10, 14, 4};
    localparam nib_t FWD_B [16] = '{6, 10, 15, 4, 14, 13, 9, 2, 1, 7, 12, 11, 0, 3, 5, 8};
    localparam nib_t FWD_C [16] = '{12, 2, 6, 1, 0, 3, 5, 8, 7, 9, 11, 14, 10, 13, 15, 4};
    localparam nib_t FWD_D [16] = '{13, 11, 2, 7, 0, 3, 5, 8, 6, 12, 15, 1, 10, 4, 9, 14};
    localparam nib_t INV_A [16] = '{4, 0, 3, 5, 15, 6, 8, 11, 7, 9, 13, 2, 10, 12, 14, 1};
    localparam nib_t INV_B [16] = '{12, 8, 7, 13, 3, 14, 0, 9, 15, 6, 1, 11, 10, 5, 4, 2};
    localparam nib_t INV_C [16] = '{4, 3, 1, 5, 15, 6, 2, 8, 7, 9, 12, 10, 0, 13, 11, 14};
    localparam nib_t INV_D [16] = '{4, 11, 2, 5, 13, 6, 8, 3, 7, 14, 12, 1, 9, 0, 15, 10};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] data;
    } cipher_req_t;

    typedef struct packed {
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] k2;
        logic [15:0] k3;
    } rotor_keys_t;

    // Eight rotor outputs of one word, element r-1 for rotor r.
    typedef logic [7:0][15:0] word_vec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    rsc_req_if req_bus ();
    rsc_rsp_if rsp_bus ();

    rotor_stream_cipher_16bit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_bus),
        .rsp_ch    (rsp_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted block state: key/IV registers, rotor words and the LFSR.
    logic [63:0] key_iv_regs [REG_COUNT];
    logic [15:0] rotor_state [8];
    logic [15:0] lfsr_state;

    // Requests waiting to be driven and output words still owed by the block.
    cipher_req_t req_backlog [$];
    logic [15:0] expected_out_words [$];

    int queued_total;
    int accepted_total;
    int fail_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    logic req_fired;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] rotl16(input logic [15:0] x, input int n);
        logic [31:0] w;
        w = {x, x} << n;
        return w[31:16];
    endfunction

    function automatic logic [15:0] sub_nibbles(input logic [15:0] x, input bit inverse);
        if (inverse)
            return {INV_A[x[15:12]], INV_B[x[11:8]], INV_C[x[7:4]], INV_D[x[3:0]]};
        return {FWD_A[x[15:12]], FWD_B[x[11:8]], FWD_C[x[7:4]], FWD_D[x[3:0]]};
    endfunction

    // Nibble XOR network followed by the rotate-XOR diffusion step.
    function automatic logic [15:0] mix_word(input logic [15:0] x);
        logic [3:0]  a, b, c, d;
        logic [15:0] y;
        a = x[15:12];
        b = x[11:8];
        c = x[7:4];
        d = x[3:0];
        a ^= c;
        b ^= d;
        c ^= b;
        d ^= a;
        y = {a, b, c, d};
        return y ^ rotl16(y, 12) ^ rotl16(y, 8);
    endfunction

    function automatic logic [15:0] unmix_word(input logic [15:0] x);
        logic [3:0]  a, b, c, d;
        logic [15:0] y;
        y = x ^ rotl16(x, 4) ^ rotl16(x, 8);
        a = y[15:12];
        b = y[11:8];
        c = y[7:4];
        d = y[3:0];
        d ^= a;
        c ^= b;
        b ^= d;
        a ^= c;
        return {a, b, c, d};
    endfunction

    function automatic logic [15:0] key_word(input int i);
        return key_iv_regs[i / 4][16 * (i % 4) +: 16];
    endfunction

    function automatic logic [15:0] iv_word(input int i);
        return key_iv_regs[4 + i / 4][16 * (i % 4) +: 16];
    endfunction

    // Rotor r (1..8) keys off key words 2r-2 and 2r-1; the two derived keys
    // are rotated copies with an S-box nibble ORed in and a rotor tweak.
    function automatic rotor_keys_t rotor_keys(input int r);
        rotor_keys_t k;
        logic [15:0] t;
        k.k0 = key_word(2 * r - 2);
        k.k1 = key_word(2 * r - 1);
        t = rotl16(k.k0, 6);
        t[9:6] = t[9:6] | FWD_A[t[9:6]];
        k.k2 = t ^ 16'(r + 2);
        t = rotl16(k.k1, 10);
        t[9:6] = t[9:6] | FWD_A[t[9:6]];
        k.k3 = t ^ 16'(r + 3);
        return k;
    endfunction

    function automatic logic [15:0] rotor_fwd(input logic [15:0] x, input int r);
        rotor_keys_t k;
        logic [15:0] t;
        k = rotor_keys(r);
        t = mix_word(sub_nibbles(x ^ k.k0, 1'b0));
        t = mix_word(sub_nibbles(t ^ k.k1, 1'b0));
        t = mix_word(sub_nibbles(t ^ k.k2, 1'b0));
        t = mix_word(sub_nibbles(t ^ k.k3, 1'b0));
        t = sub_nibbles(t ^ k.k1 ^ k.k0, 1'b0);
        return t ^ k.k2 ^ k.k3;
    endfunction

    function automatic logic [15:0] rotor_inv(input logic [15:0] x, input int r);
        rotor_keys_t k;
        logic [15:0] t;
        k = rotor_keys(r);
        t = sub_nibbles(x ^ k.k3 ^ k.k2, 1'b1) ^ k.k0 ^ k.k1;
        t = sub_nibbles(unmix_word(t), 1'b1) ^ k.k3;
        t = sub_nibbles(unmix_word(t), 1'b1) ^ k.k2;
        t = sub_nibbles(unmix_word(t), 1'b1) ^ k.k1;
        return sub_nibbles(unmix_word(t), 1'b1) ^ k.k0;
    endfunction

    // Rotor word update after a word. The order matters: the sum for word zero
    // picks up word four as already rewritten above it. The LFSR steps last and
    // feeds word four.
    task automatic advance_state(input word_vec_t v);
        rotor_state[1] = rotor_state[1] + v[0] + v[4] + rotor_state[5];
        rotor_state[2] = rotor_state[2] + v[1] + v[2] + rotor_state[3] + rotor_state[0];
        rotor_state[3] = rotor_state[3] + v[0] + v[3] + rotor_state[7];
        rotor_state[4] = rotor_state[4] + v[1];
        rotor_state[5] = rotor_state[5] + v[0] + v[3] + rotor_state[6];
        rotor_state[6] = rotor_state[6] + v[1] + v[5];
        rotor_state[7] = rotor_state[7] + v[3];
        rotor_state[0] = rotor_state[0] + v[2] + v[1] + rotor_state[4] + v[6];
        lfsr_state = (lfsr_state >> 1) ^ (lfsr_state[0] ? FEEDBACK_TAPS : 16'h0000);
        rotor_state[4] = rotor_state[4] + lfsr_state;
    endtask

    // Applies one accepted request to the predicted state and queues the
    // output word it must produce, if any.
    task automatic run_cipher_cmd(input logic [1:0] cmd, input logic [15:0] din);
        word_vec_t   v;
        logic [15:0] x;
        case (cmd)
            CMD_INIT:
            begin
                for (int i = 0; i < 8; i++)
                    rotor_state[i] = iv_word(i);
                for (int p = 0; p < 4; p++)
                begin
                    v[0] = rotor_fwd(rotor_state[0] + rotor_state[2] + rotor_state[4]
                                     + rotor_state[6], 1);
                    for (int i = 1; i < 8; i++)
                        v[i] = rotor_fwd(v[i - 1] + rotor_state[i], i + 1);
                    rotor_state[0] = rotor_state[0] + v[7];
                    for (int i = 1; i < 8; i++)
                        rotor_state[i] = rotor_state[i] + v[i - 1];
                end
                // The seed bit keeps the LFSR out of the all-zero lockup.
                lfsr_state = v[7] | FEEDBACK_SEED;
            end
            CMD_ENC:
            begin
                x = din;
                for (int i = 0; i < 8; i++)
                begin
                    x = rotor_fwd(x + rotor_state[i], i + 1);
                    v[i] = x;
                end
                advance_state(v);
                expected_out_words.push_back(x);
            end
            CMD_DEC:
            begin
                // Walk the chain backwards; v still ends up holding what each
                // rotor produced on the encrypt side so the update matches.
                x = din;
                for (int i = 8; i > 1; i--)
                begin
                    x = rotor_inv(x, i) - rotor_state[i - 1];
                    v[i - 2] = x;
                end
                x = rotor_inv(x, 1) - rotor_state[0];
                v[7] = din;
                advance_state(v);
                expected_out_words.push_back(x);
            end
            default:
            begin
                // The unused command leaves the state alone and gives nothing.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge. A request that
    // has been offered stays up until the monitor saw it accepted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        cipher_req_t nxt;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (!req_bus.valid || req_fired)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = req_backlog.pop_front();
                req_bus.valid   <= 1'b1;
                req_bus.cmd     <= nxt.cmd;
                req_bus.data_in <= nxt.data;
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
        rsp_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels and the config port on the rising
    // edge, checks results against the predictor, and runs the watchdog.
    // Results are checked before the request of the same edge is applied,
    // so an early result can never be matched against its own prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic [15:0] want;
        if (!rst_n)
        begin
            req_fired <= 1'b0;
        end
        else
        begin
            req_fired <= req_bus.valid && req_bus.ready;
            quiet_cycles++;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                quiet_cycles = 0;
                if (expected_out_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected data_out, expected none, actual %h",
                             $time, rsp_bus.data_out);
                end
                else
                begin
                    want = expected_out_words.pop_front();
                    if (rsp_bus.data_out !== want)
                    begin
                        fail_count++;
                        $display("%0t: data_out mismatch, expected %h, actual %h",
                                 $time, want, rsp_bus.data_out);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                quiet_cycles = 0;
                accepted_total++;
                run_cipher_cmd(req_bus.cmd, req_bus.data_in);
            end
            if (cfg_wr_en && cfg_index < REG_COUNT)
                key_iv_regs[cfg_index] = cfg_data;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_req(input logic [1:0] cmd, input logic [15:0] data);
        cipher_req_t item;
        item.cmd  = cmd;
        item.data = data;
        req_backlog.push_back(item);
        queued_total++;
    endtask

    // Holds the sender back until every queued request has gone in and every
    // owed result has come out, then lets a trailing initialize finish.
    task automatic wait_for_drain();
        while (accepted_total != queued_total || expected_out_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all six key/IV registers (0: all zero, 1: all ones, else
    // random), then both stray indexes, which must leave the keys untouched.
    task automatic load_registers(input int mode);
        logic [63:0] val;
        for (int i = REG_KEY_0_3; i <= REG_IV_4_7; i++)
        begin
            case (mode)
                0:       val = 64'd0;
                1:       val = '1;
                default: val = {$urandom, $urandom};
            endcase
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= val;
        end
        @(negedge clk);
        cfg_index <= REG_STRAY_6;
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
        cfg_index <= REG_STRAY_7;
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // A run of sessions, each opened by an initialize and followed by a
    // mostly encrypt/decrypt mix with the odd re-initialize or unused command.
    task automatic queue_sessions(input int items);
        int left;
        int len;
        int pick;
        left = items;
        while (left > 0)
        begin
            len = $urandom_range(50, 8);
            queue_req(CMD_INIT, 16'($urandom_range(65535)));
            for (int i = 1; i < len; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    queue_req(CMD_INIT, 16'($urandom_range(65535)));
                else if (pick < 6)
                    queue_req(CMD_UNUSED, 16'($urandom_range(65535)));
                else if (pick < 53)
                    queue_req(CMD_ENC, 16'($urandom_range(65535)));
                else
                    queue_req(CMD_DEC, 16'($urandom_range(65535)));
            end
            left -= len;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_KEY_0_3;
        cfg_data        = 64'd0;
        req_bus.valid   = 1'b0;
        req_bus.cmd     = CMD_INIT;
        req_bus.data_in = 16'h0000;
        rsp_bus.ready   = 1'b0;
        req_fired       = 1'b0;
        queued_total    = 0;
        accepted_total  = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 26;
        recv_idle_pct   = 67;
        lfsr_state      = 16'h0000;
        for (int i = 0; i < REG_COUNT; i++)
            key_iv_regs[i] = 64'd0;
        for (int i = 0; i < 8; i++)
            rotor_state[i] = 16'h0000;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Words before any initialize run on the all-zero reset state, and
        // the unused command must leave no trace.
        queue_req(CMD_ENC, 16'h0000);
        queue_req(CMD_DEC, 16'hFFFF);
        queue_req(CMD_UNUSED, 16'h1234);
        queue_req(CMD_ENC, 16'hFFFF);
        wait_for_drain();

        // All-ones key and IV, then extremes of the data word in both
        // directions, with a re-initialize part way through.
        load_registers(1);
        queue_req(CMD_INIT, 16'hFFFF);
        queue_req(CMD_ENC, 16'h0000);
        queue_req(CMD_ENC, 16'hFFFF);
        queue_req(CMD_DEC, 16'h0000);
        queue_req(CMD_DEC, 16'hFFFF);
        queue_req(CMD_ENC, 16'h8000);
        queue_req(CMD_DEC, 16'h0001);
        queue_req(CMD_UNUSED, 16'hFFFF);
        queue_req(CMD_ENC, 16'h5A5A);
        queue_req(CMD_INIT, 16'h0000);
        queue_req(CMD_DEC, 16'hA5A5);
        queue_req(CMD_ENC, 16'h7FFF);
        wait_for_drain();

        // All-zero key and IV.
        load_registers(0);
        queue_req(CMD_INIT, 16'h0000);
        queue_req(CMD_ENC, 16'h0001);
        queue_req(CMD_DEC, 16'h7FFF);
        queue_req(CMD_ENC, 16'hFFFE);
        wait_for_drain();

        // Random part: the first two segments stall mostly on the result
        // side, the next two mostly on the request side, the rest run with
        // no idling at all. Every segment starts from an idle block with a
        // fresh key, one all zero and one all ones among them.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 2)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 67;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_for_drain();
            load_registers(seg == 1 ? 0 : (seg == 4 ? 1 : 2));
            queue_sessions(SEGMENT_ITEMS);
        end

        wait_for_drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/rsc_pkg.sv
rtl/rsc_req_if.sv
rtl/rsc_rsp_if.sv
rtl/rotor_stream_cipher_16bit.sv
tb/rotor_stream_cipher_16bit_test.sv
